// ----- hdl/mlpd_pkg.sv -----
package mlpd_pkg;

    // Default store depth in bytes
    localparam int MAX_FRAME_DEF = 64;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 1;
    // Expected length is the length byte plus an offset, kept without wrap
    localparam int EXP_W = BYTE_W + 1;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST = 8'hFF;

    // Frame layout
    localparam logic [EXP_W-1:0] LEN_OFFSET = 9'd5;
    localparam int LEN_INDEX = 2;
    localparam int MIN_CLOSE = 3;
    localparam int FIRST_SUM_INDEX = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAD_CHECK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG = 2'd2;

endpackage

// ----- hdl/mlpd_store.sv -----
module mlpd_store #(
    parameter int MAX_FRAME = mlpd_pkg::MAX_FRAME_DEF,
    parameter int ADDR_W = $clog2(MAX_FRAME)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mlpd_pkg::BYTE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [mlpd_pkg::BYTE_W-1:0] rd_data
);

    logic [mlpd_pkg::BYTE_W-1:0] mem [MAX_FRAME];
    logic [mlpd_pkg::BYTE_W-1:0] rd_data_reg;

    // Write one byte, read one byte with a registered output
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/marker_length_parity_deframer.sv -----
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_valid / s_ready    | s_rx_byte
// m_       | out       | m_valid / m_ready    | m_out_byte, m_kind, m_last
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One received byte is taken per cycle in idle and collect, while the output
// register is free or being drained. A good frame leaves the store word by word; each
// word is read into the store's registered output, then loaded as the output word,
// with s_ready low meanwhile. m_ready low holds the output word and stalls both.
// Reset (aresetn, synchronous, active low) returns to waiting for the start
// marker and loads the marker registers; the store itself is not cleared.
module marker_length_parity_deframer #(
    parameter int MAX_FRAME = mlpd_pkg::MAX_FRAME_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mlpd_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mlpd_pkg::BYTE_W-1:0]    m_out_byte,
    output logic [mlpd_pkg::KIND_W-1:0]    m_kind,
    output logic                           m_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mlpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlpd_pkg::BYTE_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COLLECT = 3'b010,
        ST_EMIT    = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [mlpd_pkg::BYTE_W-1:0]   len_reg, len_next;
    logic [mlpd_pkg::BYTE_W-1:0]   last_byte_reg, last_byte_next;
    logic                          par_reg, par_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    logic [ADDR_W-1:0]             rd_addr_reg, rd_addr_next;
    logic                          fetched_reg, fetched_next;
    logic                          m_valid_reg, m_valid_next;
    logic [mlpd_pkg::BYTE_W-1:0]   m_out_byte_reg, m_out_byte_next;
    logic [mlpd_pkg::KIND_W-1:0]   m_kind_reg, m_kind_next;
    logic                          m_last_reg, m_last_next;
    logic [mlpd_pkg::BYTE_W-1:0]   start_marker_reg, end_marker_reg;

    logic                          out_free;
    logic                          in_fire;
    logic                          emit_step;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [CNT_W-1:0]              count_inc;
    logic [mlpd_pkg::BYTE_W-1:0]   len_byte;
    logic [mlpd_pkg::EXP_W-1:0]    expected;
    logic                          check_ok;
    logic                          emit_last;
    logic [mlpd_pkg::BYTE_W-1:0]   rd_data;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg != ST_EMIT) && out_free;
    assign in_fire   = s_valid && s_ready;
    assign emit_step = (state_reg == ST_EMIT) && fetched_reg && out_free;
    assign cfg_ready = 1'b1;

    assign count_inc = count_reg + CNT_W'(1);
    // The length byte may be the one arriving now
    assign len_byte  = (count_reg == CNT_W'(mlpd_pkg::LEN_INDEX)) ? s_rx_byte : len_reg;
    assign expected  = {1'b0, len_byte} + mlpd_pkg::LEN_OFFSET;
    // Check byte is the previous word; parity covers index 3 up to the one before it
    assign check_ok  = (last_byte_reg == {{(mlpd_pkg::BYTE_W-1){1'b0}}, par_reg});
    assign emit_last = ((CNT_W'(rd_addr_reg) + CNT_W'(1)) == n_reg);

    // Store writes: the start marker in idle, then each collected byte while there is room
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        if (in_fire) begin
            if (state_reg == ST_IDLE) begin
                wr_en = (s_rx_byte == start_marker_reg);
            end else if (count_reg < CNT_W'(MAX_FRAME)) begin
                wr_en   = 1'b1;
                wr_addr = count_reg[ADDR_W-1:0];
            end
        end
    end

    mlpd_store #(
        .MAX_FRAME(MAX_FRAME),
        .ADDR_W   (ADDR_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(s_rx_byte),
        .rd_addr(rd_addr_reg),
        .rd_data(rd_data)
    );

    // Frame tracking, emission and output register
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        last_byte_next  = last_byte_reg;
        par_next        = par_reg;
        n_next          = n_reg;
        rd_addr_next    = rd_addr_reg;
        fetched_next    = fetched_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_out_byte_next = m_out_byte_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                // Open a frame on the start marker, drop anything else
                if (in_fire && (s_rx_byte == start_marker_reg)) begin
                    state_next     = ST_COLLECT;
                    count_next     = CNT_W'(1);
                    last_byte_next = s_rx_byte;
                    par_next       = 1'b0;
                end
            end
            ST_COLLECT: begin
                if (in_fire) begin
                    if (count_reg >= CNT_W'(MAX_FRAME)) begin
                        // Store full: drop the frame
                        state_next      = ST_IDLE;
                        count_next      = '0;
                        m_valid_next    = 1'b1;
                        m_out_byte_next = '0;
                        m_kind_next     = mlpd_pkg::KIND_TOO_LONG;
                        m_last_next     = 1'b1;
                    end else begin
                        count_next     = count_inc;
                        len_next       = len_byte;
                        last_byte_next = s_rx_byte;
                        if (count_reg >= CNT_W'(mlpd_pkg::FIRST_SUM_INDEX + 1)) begin
                            par_next = par_reg ^ last_byte_reg[0];
                        end
                        if ((s_rx_byte == end_marker_reg) &&
                            (count_inc >= CNT_W'(mlpd_pkg::MIN_CLOSE))) begin
                            if (mlpd_pkg::EXP_W'(count_inc) == expected) begin
                                count_next = '0;
                                if (check_ok) begin
                                    state_next   = ST_EMIT;
                                    n_next       = count_inc;
                                    rd_addr_next = '0;
                                    fetched_next = 1'b0;
                                end else begin
                                    state_next      = ST_IDLE;
                                    m_valid_next    = 1'b1;
                                    m_out_byte_next = '0;
                                    m_kind_next     = mlpd_pkg::KIND_BAD_CHECK;
                                    m_last_next     = 1'b1;
                                end
                            end else if (expected > mlpd_pkg::EXP_W'(MAX_FRAME)) begin
                                state_next      = ST_IDLE;
                                count_next      = '0;
                                m_valid_next    = 1'b1;
                                m_out_byte_next = '0;
                                m_kind_next     = mlpd_pkg::KIND_TOO_LONG;
                                m_last_next     = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_EMIT: begin
                // Hand each fetched word to the output, then advance the read
                fetched_next = !emit_step;
                if (emit_step) begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = rd_data;
                    m_kind_next     = mlpd_pkg::KIND_DATA;
                    m_last_next     = emit_last;
                    rd_addr_next    = rd_addr_reg + ADDR_W'(1);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            fetched_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fetched_reg <= fetched_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg        <= len_next;
        last_byte_reg  <= last_byte_next;
        par_reg        <= par_next;
        n_reg          <= n_next;
        rd_addr_reg    <= rd_addr_next;
        m_out_byte_reg <= m_out_byte_next;
        m_kind_reg     <= m_kind_next;
        m_last_reg     <= m_last_next;
    end

    // Marker registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= mlpd_pkg::START_MARKER_RST;
            end_marker_reg   <= mlpd_pkg::END_MARKER_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mlpd_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                mlpd_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_kind     = m_kind_reg;
    assign m_last     = m_last_reg;

endmodule

// ----- hdl/mlpd_checker.sv -----
module mlpd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [mlpd_pkg::BYTE_W-1:0]    m_out_byte,
    input logic [mlpd_pkg::KIND_W-1:0]    m_kind,
    input logic                           m_last
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_kind)
            && $stable(m_last))
        else $error("stalled result word changed");

    // Error words close their run
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != mlpd_pkg::KIND_DATA) |-> m_last)
        else $error("error word without last");

    // Error words carry a zero byte
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != mlpd_pkg::KIND_DATA) |-> (m_out_byte == '0))
        else $error("error word with nonzero byte");

    // Only defined kinds leave the block
    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == mlpd_pkg::KIND_DATA) || (m_kind == mlpd_pkg::KIND_BAD_CHECK)
            || (m_kind == mlpd_pkg::KIND_TOO_LONG))
        else $error("undefined result kind");

    // After a mid-frame word, input stays stalled until the final word is loaded
    a_emit_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_kind == mlpd_pkg::KIND_DATA) && !m_last
            |=> !s_ready || (m_valid && m_last))
        else $error("input taken in the middle of a frame");

endmodule

bind marker_length_parity_deframer mlpd_checker u_mlpd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_out_byte(m_out_byte),
    .m_kind    (m_kind),
    .m_last    (m_last)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int MAX_FRAME    = mlpd_pkg::MAX_FRAME_DEF;
    // Quiet cycles after the last owed word, before the markers change
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 6;
    localparam int IDLE_LIMIT    = 2000;

    typedef struct packed {
        logic [mlpd_pkg::BYTE_W-1:0] out_byte;
        logic [mlpd_pkg::KIND_W-1:0] kind;
        logic                        last;
    } deframer_word_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_BAD_CHECK, ROW_TOO_LONG} row_check_t;

    typedef struct packed {
        logic [mlpd_pkg::BYTE_W-1:0] rx;
        row_check_t                  check;
    } stim_row_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_SHORT, SINK_LONG} sink_mode_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [mlpd_pkg::BYTE_W-1:0]    s_rx_byte = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [mlpd_pkg::BYTE_W-1:0]    m_out_byte;
    logic [mlpd_pkg::KIND_W-1:0]    m_kind;
    logic                           m_last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mlpd_pkg::CFG_IDX_W-1:0] cfg_index = mlpd_pkg::CFG_START_MARKER;
    logic [mlpd_pkg::BYTE_W-1:0]    cfg_data  = '0;

    // Shadow of the deframer: marker registers, open flag, store and fill count
    logic [mlpd_pkg::BYTE_W-1:0] start_mark = mlpd_pkg::START_MARKER_RST;
    logic [mlpd_pkg::BYTE_W-1:0] end_mark   = mlpd_pkg::END_MARKER_RST;
    logic                        rx_open    = 1'b0;
    logic [mlpd_pkg::BYTE_W-1:0] rx_store [MAX_FRAME];
    int                          rx_count   = 0;

    // Words produced by the last accepted byte, and words still owed by the block
    deframer_word_t step_words_q[$];
    deframer_word_t deframed_q[$];

    int fail_count  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int phase_items = 0;

    logic [6:0] sink_timer = '0;
    sink_mode_t sink_mode  = SINK_OPEN;

    // Directed frames under the reset markers (start 0xAA, end 0xFF)
    stim_row_t directed_rows [26] = '{
        // idle: a byte other than the start marker is dropped
        '{8'h00, ROW_QUIET},
        // shortest frame, nothing to sum, check byte zero
        '{8'hAA, ROW_QUIET}, '{8'h5A, ROW_QUIET}, '{8'h00, ROW_QUIET},
        '{8'h00, ROW_QUIET}, '{8'hFF, ROW_PREDICT},
        // shortest frame again, with a wrong check byte
        '{8'hAA, ROW_QUIET}, '{8'h01, ROW_QUIET}, '{8'h00, ROW_QUIET},
        '{8'h01, ROW_QUIET}, '{8'hFF, ROW_BAD_CHECK},
        // check byte right in bit 0 but not as a whole byte
        '{8'hAA, ROW_QUIET}, '{8'h00, ROW_QUIET}, '{8'h01, ROW_QUIET},
        '{8'h81, ROW_QUIET}, '{8'h03, ROW_QUIET}, '{8'hFF, ROW_BAD_CHECK},
        // length byte 0xFF closes at count three: 260 is past the store
        '{8'hAA, ROW_QUIET}, '{8'h00, ROW_QUIET}, '{8'hFF, ROW_TOO_LONG},
        // end markers before the stated length are kept as data
        '{8'hAA, ROW_QUIET}, '{8'hFF, ROW_QUIET}, '{8'h01, ROW_QUIET},
        '{8'hFF, ROW_QUIET}, '{8'h01, ROW_QUIET}, '{8'hFF, ROW_PREDICT}
    };

    marker_length_parity_deframer #(
        .MAX_FRAME(MAX_FRAME)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_kind    (m_kind),
        .m_last    (m_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic deframer_word_t frame_word(input logic [mlpd_pkg::BYTE_W-1:0] data,
                                                  input logic [mlpd_pkg::KIND_W-1:0] kind,
                                                  input logic last);
        deframer_word_t w;
        w.out_byte = data;
        w.kind     = kind;
        w.last     = last;
        return w;
    endfunction

    function automatic logic [mlpd_pkg::BYTE_W-1:0] rand_byte_except(
        input logic [mlpd_pkg::BYTE_W-1:0] avoid);
        logic [mlpd_pkg::BYTE_W-1:0] b;
        b = mlpd_pkg::BYTE_W'($urandom);
        while (b == avoid) b = mlpd_pkg::BYTE_W'($urandom);
        return b;
    endfunction

    // Advance the shadow by one received byte; leave the words it causes in step_words_q
    task automatic deframe_byte(input logic [mlpd_pkg::BYTE_W-1:0] b);
        int                          expected_len;
        int                          i;
        logic [mlpd_pkg::BYTE_W-1:0] parity;
        step_words_q.delete();
        if (!rx_open) begin
            if (b == start_mark) begin
                rx_store[0] = b;
                rx_count    = 1;
                rx_open     = 1'b1;
            end
            return;
        end
        // store already full: drop the frame, this byte included
        if (rx_count >= MAX_FRAME) begin
            rx_open  = 1'b0;
            rx_count = 0;
            step_words_q = {step_words_q,
                            frame_word('0, mlpd_pkg::KIND_TOO_LONG, 1'b1)};
            return;
        end
        rx_store[rx_count] = b;
        rx_count++;
        if (b != end_mark || rx_count < mlpd_pkg::MIN_CLOSE) return;
        expected_len = int'(rx_store[mlpd_pkg::LEN_INDEX]) + int'(mlpd_pkg::LEN_OFFSET);
        if (rx_count == expected_len) begin
            rx_open = 1'b0;
            parity  = '0;
            for (i = mlpd_pkg::FIRST_SUM_INDEX; i + 2 < rx_count; i++)
                parity[0] ^= rx_store[i][0];
            if (rx_store[rx_count - 2] != parity) begin
                step_words_q = {step_words_q,
                                frame_word('0, mlpd_pkg::KIND_BAD_CHECK, 1'b1)};
            end else begin
                for (i = 0; i < rx_count; i++)
                    step_words_q = {step_words_q,
                                    frame_word(rx_store[i], mlpd_pkg::KIND_DATA,
                                               i == rx_count - 1)};
            end
            rx_count = 0;
        end else if (expected_len > MAX_FRAME) begin
            rx_open  = 1'b0;
            rx_count = 0;
            step_words_q = {step_words_q,
                            frame_word('0, mlpd_pkg::KIND_TOO_LONG, 1'b1)};
        end
    endtask

    task automatic commit_step();
        deframed_q = {deframed_q, step_words_q};
        step_words_q.delete();
    endtask

    // Sender pacing: bursts of random length, random gaps, now and then a long stretch
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
        if ($urandom_range(0, 3) != 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Offer one byte, hold it until taken, then update the shadow
    task automatic push_rx_byte(input logic [mlpd_pkg::BYTE_W-1:0] b);
        pace_sender();
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        phase_items++;
        deframe_byte(b);
    endtask

    task automatic feed_byte(input logic [mlpd_pkg::BYTE_W-1:0] b);
        push_rx_byte(b);
        commit_step();
    endtask

    // Write both marker registers back to back, then drop valid
    task automatic set_markers(input logic [mlpd_pkg::BYTE_W-1:0] start_val,
                               input logic [mlpd_pkg::BYTE_W-1:0] end_val);
        cfg_valid <= 1'b1;
        cfg_index <= mlpd_pkg::CFG_START_MARKER;
        cfg_data  <= start_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        start_mark = start_val;
        cfg_index <= mlpd_pkg::CFG_END_MARKER;
        cfg_data  <= end_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        end_mark = end_val;
        cfg_valid <= 1'b0;
    endtask

    // Hold the input, wait for every owed word, then let the block go quiet
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One random sequence: mostly well-formed frames, the rest broken frames and noise
    task automatic send_random_frame(input bit force_full);
        int                          pick;
        int                          len;
        int                          i;
        logic [mlpd_pkg::BYTE_W-1:0] chk;
        logic [mlpd_pkg::BYTE_W-1:0] b;
        pick = force_full ? 75 : $urandom_range(0, 99);
        if (pick < 62) begin
            // well-formed frame, check byte sometimes corrupted
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, MAX_FRAME - 5)
                                              : $urandom_range(0, 12);
            feed_byte(start_mark);
            feed_byte(mlpd_pkg::BYTE_W'($urandom));
            feed_byte(mlpd_pkg::BYTE_W'(len));
            chk = '0;
            for (i = 0; i < len; i++) begin
                b = mlpd_pkg::BYTE_W'($urandom);
                chk[0] ^= b[0];
                feed_byte(b);
            end
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 1) == 0) chk[0] = ~chk[0];
                else chk = chk | (mlpd_pkg::BYTE_W'(2) << $urandom_range(0, 6));
            end
            feed_byte(chk);
            feed_byte(end_mark);
        end else if (pick < 72) begin
            // stated length past the store, closed early by an end marker
            feed_byte(start_mark);
            feed_byte(mlpd_pkg::BYTE_W'($urandom));
            feed_byte(mlpd_pkg::BYTE_W'($urandom_range(MAX_FRAME - 4, 255)));
            len = $urandom_range(0, 4);
            for (i = 0; i < len; i++) feed_byte(mlpd_pkg::BYTE_W'($urandom));
            feed_byte(end_mark);
        end else if (pick < 78) begin
            // fill the store without a closing marker, then one byte more
            feed_byte(start_mark);
            feed_byte(mlpd_pkg::BYTE_W'($urandom));
            feed_byte(mlpd_pkg::BYTE_W'($urandom_range(0, MAX_FRAME - 5)));
            for (i = 3; i < MAX_FRAME; i++) feed_byte(rand_byte_except(end_mark));
            case ($urandom_range(0, 2))
                0: feed_byte(end_mark);
                1: feed_byte(start_mark);
                default: feed_byte(mlpd_pkg::BYTE_W'($urandom));
            endcase
        end else if (pick < 90) begin
            // end marker after the stated length: frame stays open
            feed_byte(start_mark);
            feed_byte(mlpd_pkg::BYTE_W'($urandom));
            len = $urandom_range(0, 8);
            feed_byte(mlpd_pkg::BYTE_W'(len));
            len = len + 1 + $urandom_range(1, 6);
            for (i = 0; i < len; i++) feed_byte(rand_byte_except(end_mark));
            feed_byte(end_mark);
        end else begin
            // line noise
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) feed_byte(mlpd_pkg::BYTE_W'($urandom));
        end
    endtask

    task automatic run_random_phase(input bit want_full);
        phase_items = 0;
        if (want_full) send_random_frame(1'b1);
        while (phase_items < PHASE_ITEMS) send_random_frame(1'b0);
        drain_and_settle();
    endtask

    // Result sink: a new ready pattern is drawn each time the 7-bit timer wraps
    always @(posedge aclk) begin
        sink_timer <= sink_timer + 1'b1;
        if (sink_timer == '1) sink_mode <= sink_mode_t'($urandom_range(0, 3));
        case (sink_mode)
            SINK_OPEN:   m_ready <= 1'b1;
            SINK_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
            SINK_SHORT:  m_ready <= (sink_timer[3:0] < 4'd12);
            default:     m_ready <= (sink_timer[5:3] != 3'd0);
        endcase
    end

    // Check each accepted word against the oldest owed word
    always @(posedge aclk) begin
        deframer_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (deframed_q.size() == 0) begin
                $error("unexpected word: out_byte 0x%02h kind %0d last %0d",
                       m_out_byte, m_kind, m_last);
                fail_count++;
            end else begin
                want = deframed_q.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("m_out_byte: expected 0x%02h, got 0x%02h", want.out_byte, m_out_byte);
                    fail_count++;
                end
                if (m_kind !== want.kind) begin
                    $error("m_kind: expected %0d, got %0d", want.kind, m_kind);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("m_last: expected %0d, got %0d", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no handshake for %0d cycles, %0d words still owed",
                       IDLE_LIMIT, deframed_q.size());
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t row;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames; quiet and error rows carry their own expectation
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            push_rx_byte(row.rx);
            case (row.check)
                ROW_PREDICT:   commit_step();
                ROW_QUIET:     step_words_q.delete();
                ROW_BAD_CHECK: deframed_q = {deframed_q,
                                   frame_word('0, mlpd_pkg::KIND_BAD_CHECK, 1'b1)};
                default:       deframed_q = {deframed_q,
                                   frame_word('0, mlpd_pkg::KIND_TOO_LONG, 1'b1)};
            endcase
        end

        // Random traffic under several marker settings, extremes included
        run_random_phase(1'b0);
        set_markers(8'h00, 8'hFF);
        run_random_phase(1'b1);
        set_markers(8'hFF, 8'h00);
        run_random_phase(1'b0);
        begin
            logic [mlpd_pkg::BYTE_W-1:0] s_mark;
            s_mark = mlpd_pkg::BYTE_W'($urandom);
            set_markers(s_mark, ($urandom_range(0, 3) == 0) ? s_mark
                                                           : mlpd_pkg::BYTE_W'($urandom));
        end
        run_random_phase(1'b0);
        set_markers(mlpd_pkg::START_MARKER_RST, mlpd_pkg::END_MARKER_RST);
        run_random_phase(1'b0);

        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- marker_length_parity_deframer.f -----
hdl/mlpd_pkg.sv
hdl/mlpd_store.sv
hdl/marker_length_parity_deframer.sv
hdl/mlpd_checker.sv
dv/tb_top.sv
